// ----- src/drc_pkg.sv -----
package drc_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int MAP_BITS      = 6;
    localparam int ADDR_W        = 2 * MAP_BITS;
    localparam int SCREEN_HEIGHT = 480;
    localparam int STEP_LIMIT    = 130;
    localparam int DIVD_W        = 40;
    localparam int DIVS_W        = 22;
    localparam int DIV_CNT_W     = 6;

    localparam logic [21:0] PERP_MAX   = 22'h3FFFFF;
    localparam logic [15:0] HEIGHT_MAX = 16'hFFFF;

    localparam logic [2:0] REG_CAMERA_X = 3'd0;
    localparam logic [2:0] REG_CAMERA_Y = 3'd1;
    localparam logic [2:0] REG_DIR_X    = 3'd2;
    localparam logic [2:0] REG_DIR_Y    = 3'd3;
    localparam logic [2:0] REG_PLANE_X  = 3'd4;
    localparam logic [2:0] REG_PLANE_Y  = 3'd5;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_CAST  = 1'b1
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [7:0] cell_value;
        logic [9:0] column;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctrl_t;

    typedef struct packed {
        logic        [21:0] camera_x;
        logic        [21:0] camera_y;
        logic signed [17:0] dir_x;
        logic signed [17:0] dir_y;
        logic signed [17:0] plane_x;
        logic signed [17:0] plane_y;
    } cam_cfg_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CAM0,
        ST_CAM1,
        ST_MULX,
        ST_MULY,
        ST_RAY,
        ST_YSET,
        ST_PMUL,
        ST_QMUL,
        ST_STEP,
        ST_CHECK,
        ST_DIVP,
        ST_WAITP,
        ST_DIVH,
        ST_WAITH,
        ST_EMIT
    } back_state_t;

endpackage

// ----- src/dda_raycast_column_top.sv -----
// Operation: a map write is done as the back end pops it; a cast runs states CAM0 to QMUL,
// then STEP and CHECK per grid step (up to 130 steps, one registered map read each) and,
// on a hit, up to two divides: perpendicular distance, then slice height.
// Throughput: one transaction at a time in the back end; a 2-entry queue buffers input.
// Reset: asynchronous, active low; the map's 4096 cells are then zeroed, input stalled.
module dda_raycast_column_top
    import drc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic [7:0]  cell_value,
    input  logic [9:0]  column,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  out_column,
    output logic        hit_side,
    output logic [5:0]  hit_x,
    output logic [5:0]  hit_y,
    output logic [7:0]  wall_value,
    output logic [21:0] perp_distance,
    output logic [15:0] slice_height,
    output logic [8:0]  row_first,
    output logic [8:0]  row_last,
    output logic        status
);

    cam_cfg_t          cfg_reg, cfg_next;
    logic              cfg_we;
    logic [2:0]        reg_idx;
    queue_head_t       head;
    back_ctrl_t        ctrl;
    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic              div_done;
    logic [DIVD_W-1:0] div_quotient;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx)
                REG_CAMERA_X: cfg_next.camera_x = pwdata[21:0];
                REG_CAMERA_Y: cfg_next.camera_y = pwdata[21:0];
                REG_DIR_X:    cfg_next.dir_x    = pwdata[17:0];
                REG_DIR_Y:    cfg_next.dir_y    = pwdata[17:0];
                REG_PLANE_X:  cfg_next.plane_x  = pwdata[17:0];
                REG_PLANE_Y:  cfg_next.plane_y  = pwdata[17:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CAMERA_X: prdata = {10'b0, cfg_reg.camera_x};
            REG_CAMERA_Y: prdata = {10'b0, cfg_reg.camera_y};
            REG_DIR_X:    prdata = 32'(cfg_reg.dir_x);
            REG_DIR_Y:    prdata = 32'(cfg_reg.dir_y);
            REG_PLANE_X:  prdata = 32'(cfg_reg.plane_x);
            REG_PLANE_Y:  prdata = 32'(cfg_reg.plane_y);
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.camera_x <= 22'd131072;
            cfg_reg.camera_y <= 22'd131072;
            cfg_reg.dir_x    <= -18'sd65536;
            cfg_reg.dir_y    <= 18'sd0;
            cfg_reg.plane_x  <= 18'sd0;
            cfg_reg.plane_y  <= 18'sd43254;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    drc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_value (cell_value),
        .column     (column),
        .ctrl       (ctrl),
        .head       (head)
    );

    drc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    drc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .ctrl          (ctrl),
        .cfg           (cfg_reg),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_quotient  (div_quotient),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_column    (out_column),
        .hit_side      (hit_side),
        .hit_x         (hit_x),
        .hit_y         (hit_y),
        .wall_value    (wall_value),
        .perp_distance (perp_distance),
        .slice_height  (slice_height),
        .row_first     (row_first),
        .row_last      (row_last),
        .status        (status)
    );

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> perp_distance == 22'd0 && slice_height == 16'd0
                                && wall_value == 8'd0)
        else $error("miss result carries hit data");

    a_hit_wall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status |-> wall_value != 8'd0)
        else $error("hit result with empty cell");

    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status |-> row_first <= row_last)
        else $error("draw span inverted");

    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clearing |-> in_stall && !out_valid)
        else $error("traffic during map clear");

endmodule

// ----- src/drc_front.sv -----
module drc_front
    import drc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic [7:0]  cell_value,
    input  logic [9:0]  column,
    input  back_ctrl_t  ctrl,
    output queue_head_t head
);

    item_t      slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       push;
    logic       pop;
    item_t      in_item;

    always_comb
    begin
        in_item.op         = mode ? OP_CAST : OP_WRITE;
        in_item.cell_x     = cell_x;
        in_item.cell_y     = cell_y;
        in_item.cell_value = cell_value;
        in_item.column     = column;
    end

    assign in_stall   = (count_reg == 2'd2) || ctrl.clearing;
    assign push       = in_valid && !in_stall;
    assign pop        = ctrl.pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- src/drc_div.sv -----
module drc_div
    import drc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVS_W-1:0]    rem_reg, rem_next;
    logic [DIVD_W-1:0]    quo_reg, quo_next;
    logic [DIVS_W-1:0]    den_reg, den_next;
    logic [DIVS_W:0]      rem_sh;
    logic [DIVS_W:0]      rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[DIVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sub[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/drc_back.sv -----
module drc_back
    import drc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  queue_head_t       head,
    output back_ctrl_t        ctrl,
    input  cam_cfg_t          cfg,
    output logic              div_start,
    output logic [DIVD_W-1:0] div_dividend,
    output logic [DIVS_W-1:0] div_divisor,
    input  logic              div_done,
    input  logic [DIVD_W-1:0] div_quotient,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [9:0]        out_column,
    output logic              hit_side,
    output logic [5:0]        hit_x,
    output logic [5:0]        hit_y,
    output logic [7:0]        wall_value,
    output logic [21:0]       perp_distance,
    output logic [15:0]       slice_height,
    output logic [8:0]        row_first,
    output logic [8:0]        row_last,
    output logic              status
);

    back_state_t state_reg, state_next;

    logic [7:0]        grid_mem [1 << ADDR_W];
    logic [7:0]        rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [9:0]        column_reg, column_next;
    logic [9:0]        cam_q_reg, cam_q_next;
    logic signed [18:0] cam_reg, cam_next;
    logic signed [36:0] prod_reg, prod_next;
    logic signed [19:0] rx_reg, rx_next;
    logic signed [19:0] ry_reg, ry_next;
    logic              neg_x_reg, neg_x_next;
    logic              neg_y_reg, neg_y_next;
    logic [18:0]       ax_reg, ax_next;
    logic [18:0]       ay_reg, ay_next;
    logic [23:0]       dist_x_reg, dist_x_next;
    logic [23:0]       dist_y_reg, dist_y_next;
    logic [43:0]       p_reg, p_next;
    logic [43:0]       q_reg, q_next;
    logic signed [7:0] px_reg, px_next;
    logic signed [7:0] py_reg, py_next;
    logic              side_reg, side_next;
    logic [7:0]        step_reg, step_next;
    logic              miss_reg, miss_next;
    logic [7:0]        wall_reg, wall_next;
    logic [21:0]       perp_reg, perp_next;
    logic [15:0]       lh_reg, lh_next;

    logic              out_valid_reg, out_valid_next;
    logic [9:0]        o_column_reg;
    logic              o_side_reg;
    logic [5:0]        o_x_reg;
    logic [5:0]        o_y_reg;
    logic [7:0]        o_wall_reg;
    logic [21:0]       o_perp_reg;
    logic [15:0]       o_lh_reg;
    logic [8:0]        o_ds_reg;
    logic [8:0]        o_de_reg;
    logic              o_status_reg;
    logic              out_load;

    logic [11:0]        colx4;
    logic [21:0]        q0_prod;
    logic [11:0]        cam_rem;
    logic [9:0]         cam_q;
    logic [17:0]        cam_base;
    logic signed [20:0] ray_sum;
    logic [42:0]        pmul;
    logic [42:0]        qmul;
    logic               step_x;
    logic signed [7:0]  px_step;
    logic signed [7:0]  py_step;
    logic               off_map;
    logic [18:0]        den;
    logic [6:0]         num_cell;
    logic signed [23:0] num;
    logic [22:0]        num_mag;
    logic [14:0]        half_lh;
    logic [8:0]         ds_val;
    logic [8:0]         de_val;

    assign colx4    = {column_reg, 2'b00};
    assign q0_prod  = colx4 * 10'd819;
    assign cam_rem  = colx4 - (12'(cam_q_reg) * 12'd5);
    assign cam_q    = (cam_rem >= 12'd5) ? cam_q_reg + 10'd1 : cam_q_reg;
    assign cam_base = (18'(column_reg) * 18'd204) + {8'b0, cam_q};

    assign pmul = dist_x_reg * ay_reg;
    assign qmul = dist_y_reg * ax_reg;

    assign step_x  = (p_reg < q_reg);
    assign px_step = step_x ? (neg_x_reg ? px_reg - 8'sd1 : px_reg + 8'sd1) : px_reg;
    assign py_step = step_x ? py_reg : (neg_y_reg ? py_reg - 8'sd1 : py_reg + 8'sd1);
    assign off_map = (px_step[7:MAP_BITS] != '0) || (py_step[7:MAP_BITS] != '0);

    assign den      = side_reg ? ay_reg : ax_reg;
    assign num_cell = side_reg ? ({1'b0, py_reg[5:0]} + {6'b0, neg_y_reg})
                               : ({1'b0, px_reg[5:0]} + {6'b0, neg_x_reg});
    assign num      = $signed({1'b0, num_cell, 16'b0})
                    - $signed({2'b0, side_reg ? cfg.camera_y : cfg.camera_x});
    assign num_mag  = num[23] ? 23'(-num) : num[22:0];

    assign half_lh = lh_reg[15:1];
    assign ds_val  = (half_lh >= 15'd240) ? 9'd0 : 9'(15'd240 - half_lh);
    assign de_val  = (half_lh >= 15'd240) ? 9'(SCREEN_HEIGHT - 1) : 9'(half_lh + 15'd240);

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid && head.item.op == OP_CAST)
                begin
                    state_next = ST_CAM0;
                end
            end
            ST_CAM0: state_next = ST_CAM1;
            ST_CAM1: state_next = ST_MULX;
            ST_MULX: state_next = ST_MULY;
            ST_MULY: state_next = ST_RAY;
            ST_RAY:  state_next = ST_YSET;
            ST_YSET: state_next = ST_PMUL;
            ST_PMUL: state_next = ST_QMUL;
            ST_QMUL: state_next = ST_STEP;
            ST_STEP: state_next = off_map ? ST_EMIT : ST_CHECK;
            ST_CHECK:
            begin
                if (rd_data_reg != 8'd0)
                begin
                    state_next = ST_DIVP;
                end
                else if (step_reg == 8'(STEP_LIMIT))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_DIVP:  state_next = (den == '0) ? ST_DIVH : ST_WAITP;
            ST_WAITP: state_next = div_done ? ST_DIVH : ST_WAITP;
            ST_DIVH:  state_next = (perp_reg == '0) ? ST_EMIT : ST_WAITH;
            ST_WAITH: state_next = div_done ? ST_EMIT : ST_WAITH;
            ST_EMIT:  state_next = out_load ? ST_IDLE : ST_EMIT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        column_next  = column_reg;
        cam_q_next   = cam_q_reg;
        cam_next     = cam_reg;
        prod_next    = prod_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        neg_x_next   = neg_x_reg;
        neg_y_next   = neg_y_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        dist_x_next  = dist_x_reg;
        dist_y_next  = dist_y_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        side_next    = side_reg;
        step_next    = step_reg;
        miss_next    = miss_reg;
        wall_next    = wall_reg;
        perp_next    = perp_reg;
        lh_next      = lh_reg;
        ray_sum      = '0;
        ctrl.pop      = 1'b0;
        ctrl.clearing = (state_reg == ST_CLEAR);
        mem_we       = 1'b0;
        mem_waddr    = clr_cnt_reg;
        mem_wdata    = 8'd0;
        mem_raddr    = {px_step[MAP_BITS-1:0], py_step[MAP_BITS-1:0]};
        div_start    = 1'b0;
        div_dividend = {1'b0, num_mag, 16'b0};
        div_divisor  = {3'b0, den};
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    ctrl.pop    = 1'b1;
                    column_next = head.item.column;
                    if (head.item.op == OP_WRITE)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = {head.item.cell_x, head.item.cell_y};
                        mem_wdata = head.item.cell_value;
                    end
                end
            end
            ST_CAM0: cam_q_next = q0_prod[21:12];
            ST_CAM1: cam_next   = $signed({1'b0, cam_base}) - 19'sd65536;
            ST_MULX: prod_next  = cfg.plane_x * cam_reg;
            ST_MULY:
            begin
                ray_sum   = {{3{cfg.dir_x[17]}}, cfg.dir_x} + prod_reg[36:16];
                rx_next   = ray_sum[19:0];
                prod_next = cfg.plane_y * cam_reg;
            end
            ST_RAY:
            begin
                ray_sum    = {{3{cfg.dir_y[17]}}, cfg.dir_y} + prod_reg[36:16];
                ry_next    = ray_sum[19:0];
                neg_x_next = rx_reg[19];
                ax_next    = rx_reg[19] ? 19'(-rx_reg) : rx_reg[18:0];
                dist_x_next = rx_reg[19] ? {8'b0, cfg.camera_x[15:0]}
                                         : 24'(17'h10000 - {1'b0, cfg.camera_x[15:0]});
                px_next    = {2'b0, cfg.camera_x[21:16]};
                py_next    = {2'b0, cfg.camera_y[21:16]};
                step_next  = 8'd0;
                miss_next  = 1'b0;
                side_next  = 1'b0;
            end
            ST_YSET:
            begin
                neg_y_next  = ry_reg[19];
                ay_next     = ry_reg[19] ? 19'(-ry_reg) : ry_reg[18:0];
                dist_y_next = ry_reg[19] ? {8'b0, cfg.camera_y[15:0]}
                                         : 24'(17'h10000 - {1'b0, cfg.camera_y[15:0]});
            end
            ST_PMUL: p_next = {1'b0, pmul};
            ST_QMUL: q_next = {1'b0, qmul};
            ST_STEP:
            begin
                if (step_x)
                begin
                    p_next    = p_reg + {9'b0, ay_reg, 16'b0};
                    side_next = 1'b0;
                end
                else
                begin
                    q_next    = q_reg + {9'b0, ax_reg, 16'b0};
                    side_next = 1'b1;
                end
                px_next   = px_step;
                py_next   = py_step;
                step_next = step_reg + 8'd1;
                miss_next = off_map;
            end
            ST_CHECK:
            begin
                wall_next = rd_data_reg;
                if (rd_data_reg == 8'd0 && step_reg == 8'(STEP_LIMIT))
                begin
                    miss_next = 1'b1;
                end
            end
            ST_DIVP:
            begin
                if (den == '0)
                begin
                    perp_next = PERP_MAX;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            ST_WAITP:
            begin
                if (div_done)
                begin
                    perp_next = (div_quotient > DIVD_W'(PERP_MAX)) ? PERP_MAX
                                                                    : div_quotient[21:0];
                end
            end
            ST_DIVH:
            begin
                div_dividend = DIVD_W'(SCREEN_HEIGHT) << FRAC_BITS;
                div_divisor  = DIVS_W'(perp_reg);
                if (perp_reg == '0)
                begin
                    lh_next = HEIGHT_MAX;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            ST_WAITH:
            begin
                if (div_done)
                begin
                    lh_next = (div_quotient > DIVD_W'(HEIGHT_MAX)) ? HEIGHT_MAX
                                                                    : div_quotient[15:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        column_reg <= column_next;
        cam_q_reg  <= cam_q_next;
        cam_reg    <= cam_next;
        prod_reg   <= prod_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        dist_x_reg <= dist_x_next;
        dist_y_reg <= dist_y_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        side_reg   <= side_next;
        step_reg   <= step_next;
        miss_reg   <= miss_next;
        wall_reg   <= wall_next;
        perp_reg   <= perp_next;
        lh_reg     <= lh_next;
        if (out_load)
        begin
            o_column_reg <= column_reg;
            o_status_reg <= miss_reg;
            o_side_reg   <= miss_reg ? 1'b0 : side_reg;
            o_x_reg      <= miss_reg ? 6'd0 : px_reg[5:0];
            o_y_reg      <= miss_reg ? 6'd0 : py_reg[5:0];
            o_wall_reg   <= miss_reg ? 8'd0 : wall_reg;
            o_perp_reg   <= miss_reg ? 22'd0 : perp_reg;
            o_lh_reg     <= miss_reg ? 16'd0 : lh_reg;
            o_ds_reg     <= miss_reg ? 9'd0 : ds_val;
            o_de_reg     <= miss_reg ? 9'd0 : de_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= grid_mem[mem_raddr];
    end

    assign out_valid     = out_valid_reg;
    assign out_column    = o_column_reg;
    assign hit_side      = o_side_reg;
    assign hit_x         = o_x_reg;
    assign hit_y         = o_y_reg;
    assign wall_value    = o_wall_reg;
    assign perp_distance = o_perp_reg;
    assign slice_height  = o_lh_reg;
    assign row_first     = o_ds_reg;
    assign row_last      = o_de_reg;
    assign status        = o_status_reg;

endmodule

// ----- sim/dda_raycast_column_checker.sv -----
`timescale 1ns / 100ps

module dda_raycast_column_checker
    import drc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        mode,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic [7:0]  cell_value,
    input  logic [9:0]  column,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [9:0]  out_column,
    input  logic        hit_side,
    input  logic [5:0]  hit_x,
    input  logic [5:0]  hit_y,
    input  logic [7:0]  wall_value,
    input  logic [21:0] perp_distance,
    input  logic [15:0] slice_height,
    input  logic [8:0]  row_first,
    input  logic [8:0]  row_last,
    input  logic        status,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [9:0]  col;
        logic        side;
        logic [5:0]  hx;
        logic [5:0]  hy;
        logic [7:0]  wall;
        logic [21:0] perp;
        logic [15:0] height;
        logic [8:0]  dstart;
        logic [8:0]  dend;
        logic        left_map;
    } column_hit_t;

    logic [7:0] wall_map [0:4095];
    cam_cfg_t   cam;
    column_hit_t hits_due [$];

    function automatic column_hit_t cast_column(logic [9:0] col);
        column_hit_t r;
        longint c, rx, ry, ax, ay, px, py, sx, sy, cx, cy, dx, dy, num, den, perp, lh, ds, de;
        logic [7:0] w;
        bit found;
        int side;
        r = '0;
        r.col = col;
        found = 0;
        side = 0;
        w = 0;
        c = (longint'(col) * 2 * 65536) / 640 - 65536;
        rx = longint'(cam.dir_x) + ((longint'(cam.plane_x) * c) >>> FRAC_BITS);
        ry = longint'(cam.dir_y) + ((longint'(cam.plane_y) * c) >>> FRAC_BITS);
        ax = rx < 0 ? -rx : rx;
        ay = ry < 0 ? -ry : ry;
        cx = longint'(cam.camera_x);
        cy = longint'(cam.camera_y);
        px = cx >> FRAC_BITS;
        py = cy >> FRAC_BITS;
        sx = rx < 0 ? -1 : 1;
        sy = ry < 0 ? -1 : 1;
        dx = rx < 0 ? cx - (px << FRAC_BITS) : ((px + 1) << FRAC_BITS) - cx;
        dy = ry < 0 ? cy - (py << FRAC_BITS) : ((py + 1) << FRAC_BITS) - cy;
        for (int s = 0; s < STEP_LIMIT; s++)
        begin
            if (dx * ay < dy * ax)
            begin
                dx += 65536;
                px += sx;
                side = 0;
            end
            else
            begin
                dy += 65536;
                py += sy;
                side = 1;
            end
            if (px < 0 || px >= 64 || py < 0 || py >= 64)
                break;
            w = wall_map[px * 64 + py];
            if (w != 0)
            begin
                found = 1;
                break;
            end
        end
        if (!found)
        begin
            r.left_map = 1;
            return r;
        end
        if (side == 0)
        begin
            num = ((px + (sx < 0 ? 1 : 0)) << FRAC_BITS) - cx;
            den = ax;
        end
        else
        begin
            num = ((py + (sy < 0 ? 1 : 0)) << FRAC_BITS) - cy;
            den = ay;
        end
        if (num < 0)
            num = -num;
        if (den == 0)
            perp = 4194303;
        else
        begin
            perp = (num << FRAC_BITS) / den;
            if (perp > 4194303)
                perp = 4194303;
        end
        if (perp == 0)
            lh = 65535;
        else
        begin
            lh = (longint'(SCREEN_HEIGHT) << FRAC_BITS) / perp;
            if (lh > 65535)
                lh = 65535;
        end
        ds = SCREEN_HEIGHT / 2 - lh / 2;
        if (ds < 0)
            ds = 0;
        de = lh / 2 + SCREEN_HEIGHT / 2;
        if (de >= SCREEN_HEIGHT)
            de = SCREEN_HEIGHT - 1;
        r.side = side[0];
        r.hx = px[5:0];
        r.hy = py[5:0];
        r.wall = w;
        r.perp = perp[21:0];
        r.height = lh[15:0];
        r.dstart = ds[8:0];
        r.dend = de[8:0];
        return r;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    initial
    begin
        errors = 0;
        for (int i = 0; i < 4096; i++)
            wall_map[i] = 0;
        cam.camera_x = 22'd131072;
        cam.camera_y = 22'd131072;
        cam.dir_x = -18'sd65536;
        cam.dir_y = 18'sd0;
        cam.plane_x = 18'sd0;
        cam.plane_y = 18'sd43254;
    end

    assign pending = hits_due.size();

    always @(posedge clk)
    begin
        column_hit_t want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_CAMERA_X: cam.camera_x = pwdata[21:0];
                    REG_CAMERA_Y: cam.camera_y = pwdata[21:0];
                    REG_DIR_X:    cam.dir_x = pwdata[17:0];
                    REG_DIR_Y:    cam.dir_y = pwdata[17:0];
                    REG_PLANE_X:  cam.plane_x = pwdata[17:0];
                    REG_PLANE_Y:  cam.plane_y = pwdata[17:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (mode == OP_WRITE)
                    wall_map[{cell_x, cell_y}] = cell_value;
                else
                    hits_due.push_back(cast_column(column));
            end
            if (out_valid && !out_stall)
            begin
                if (hits_due.size() == 0)
                begin
                    $display("%0t: unexpected transaction, column %0d", $time, out_column);
                    errors++;
                end
                else
                begin
                    want = hits_due.pop_front();
                    check_field("out_column", want.col, out_column);
                    check_field("hit_side", want.side, hit_side);
                    check_field("hit_x", want.hx, hit_x);
                    check_field("hit_y", want.hy, hit_y);
                    check_field("wall_value", want.wall, wall_value);
                    check_field("perp_distance", want.perp, perp_distance);
                    check_field("slice_height", want.height, slice_height);
                    check_field("row_first", want.dstart, row_first);
                    check_field("row_last", want.dend, row_last);
                    check_field("status", want.left_map, status);
                end
            end
        end
    end

endmodule

// ----- sim/tb_dda_raycast_column_top.sv -----
`timescale 1ns / 100ps

module tb_dda_raycast_column_top;
    import drc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [7:0]  cell_value;
    logic [9:0]  column;
    logic        out_valid;
    logic        out_stall;
    logic [9:0]  out_column;
    logic        hit_side;
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic [7:0]  wall_value;
    logic [21:0] perp_distance;
    logic [15:0] slice_height;
    logic [8:0]  row_first;
    logic [8:0]  row_last;
    logic        status;
    int          errors;
    int          pending;
    int          quiet_cycles;
    int          stall_tick;
    int          burst_left;

    dda_raycast_column_top uut (.*);
    dda_raycast_column_checker checker_i (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        in_valid = 0;
        mode = OP_WRITE;
        cell_x = 0;
        cell_y = 0;
        cell_value = 0;
        column = 0;
        out_stall = 0;
    end

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        case ((stall_tick >> 9) % 3)
            0: out_stall <= 0;
            1: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 15) < 13);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] index, logic [31:0] value);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic set_camera(logic [21:0] px, logic [21:0] py, logic [17:0] dx,
                              logic [17:0] dy, logic [17:0] qx, logic [17:0] qy);
        drain();
        reg_write(REG_CAMERA_X, {10'b0, px});
        reg_write(REG_CAMERA_Y, {10'b0, py});
        reg_write(REG_DIR_X, {{14{dx[17]}}, dx});
        reg_write(REG_DIR_Y, {{14{dy[17]}}, dy});
        reg_write(REG_PLANE_X, {{14{qx[17]}}, qx});
        reg_write(REG_PLANE_Y, {{14{qy[17]}}, qy});
    endtask

    task automatic send(logic m, logic [5:0] x, logic [5:0] y, logic [7:0] v, logic [9:0] c);
        if (burst_left == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1;
        mode <= m;
        cell_x <= x;
        cell_y <= y;
        cell_value <= v;
        column <= c;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic cast(logic [9:0] c);
        send(OP_CAST, 6'($urandom), 6'($urandom), 8'($urandom), c);
    endtask

    task automatic put_wall(logic [5:0] x, logic [5:0] y, logic [7:0] v);
        send(OP_WRITE, x, y, v, 10'($urandom));
    endtask

    initial
    begin
        logic [5:0] hx;
        logic [5:0] hy;
        logic [21:0] camx;
        logic [21:0] camy;
        stall_tick = 0;
        quiet_cycles = 0;
        burst_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;

        // empty map: every ray leaves
        cast(10'd0);
        cast(10'd320);
        put_wall(6'd0, 6'd2, 8'hFF);
        put_wall(6'd2, 6'd1, 8'd1);
        put_wall(6'd4, 6'd2, 8'h80);
        put_wall(6'd2, 6'd4, 8'h7F);
        put_wall(6'd63, 6'd63, 8'hAA);
        put_wall(6'd63, 6'd63, 8'h00);
        cast(10'd0);
        cast(10'd320);
        cast(10'd639);
        cast(10'd1023);
        set_camera(22'd131072, 22'd131072, 18'sd65536, 18'sd0, 18'sd0, 18'sd0);
        cast(10'd320);
        cast(10'd512);
        set_camera(22'd131072, 22'd131072, 18'sd0, 18'sd0, 18'sd0, 18'sd0);
        cast(10'd320);
        set_camera(22'd163840, 22'd131072, 18'sd0, -18'sd65536, 18'sd43254, 18'sd0);
        cast(10'd320);
        cast(10'd100);

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 0)
                set_camera(22'd0, 22'd0, -18'sd131072, -18'sd131072,
                           18'sd131071, 18'sd131071);
            else if (ph == 1)
                set_camera(22'h3FFFFF, 22'h3FFFFF, 18'sd131071, 18'sd131071,
                           -18'sd131072, -18'sd131072);
            else
                set_camera(22'($urandom), 22'($urandom), 18'($urandom), 18'($urandom),
                           18'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 65535)),
                           18'($urandom));
            camx = checker_i.cam.camera_x;
            camy = checker_i.cam.camera_y;
            for (int i = 0; i < 118; i++)
            begin
                if ($urandom_range(0, 9) < 4)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        hx = camx[21:16] + 6'($signed($urandom_range(0, 8)) - 4);
                        hy = camy[21:16] + 6'($signed($urandom_range(0, 8)) - 4);
                    end
                    else
                    begin
                        hx = 6'($urandom);
                        hy = 6'($urandom);
                    end
                    put_wall(hx, hy, 8'(($urandom_range(0, 9) < 8) ? $urandom : 0));
                end
                else
                    cast(10'(($urandom_range(0, 9) < 9) ? $urandom_range(0, 639)
                                                        : $urandom_range(640, 1023)));
            end
        end

        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
src/drc_pkg.sv
src/drc_front.sv
src/drc_div.sv
src/drc_back.sv
src/dda_raycast_column_top.sv
sim/dda_raycast_column_checker.sv
sim/tb_dda_raycast_column_top.sv
